/* rtl/core/sjn_pkg.sv */
package sjn_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   localparam logic OP_TICK   = 1'b0;
   localparam logic OP_ARRIVE = 1'b1;

   typedef struct packed {
      logic        operation;
      logic [7:0]  task_id;
      logic [15:0] run_length;
      logic [15:0] requested_time;
   } req_type;

   typedef struct packed {
      logic [31:0] cycle_now;
      logic [7:0]  running_task;
      logic        busy_res;
      logic        dispatched;
      logic [4:0]  waiting_count;
      logic        accepted;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  task_id;
      logic [15:0] run_length;
      logic [15:0] requested_time;
   } entry_type;

   // the command for the whole chain of cells: push and pop are never both set
   typedef struct packed {
      logic push;
      logic pop;
   } queue_cmd_type;

   typedef struct packed {
      entry_type        head;
      logic             head_valid;
      logic             full;
      logic [CNT_W-1:0] count;
   } queue_status_type;

endpackage

/* rtl/core/sjn_cell.sv */
module sjn_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  sjn_pkg::queue_cmd_type cmd,
   input  sjn_pkg::entry_type    new_entry,
   input  sjn_pkg::entry_type    left_entry,
   input  logic                  left_valid,
   input  logic                  left_keep,
   input  sjn_pkg::entry_type    right_entry,
   input  logic                  right_valid,
   output sjn_pkg::entry_type    entry,
   output logic                  valid,
   output logic                  keep
);
   import sjn_pkg::*;

   entry_type entry_ff, entry_in;
   logic      valid_ff, valid_in;

   // an entry stays put on insertion when its key does not exceed the new one,
   // so equal keys keep arrival order
   assign keep = valid_ff && (entry_ff.requested_time <= new_entry.requested_time);

   always_comb begin
      entry_in = entry_ff;
      valid_in = valid_ff;
      if (cmd.push) begin
         if (!keep) begin
            if (left_keep) begin
               entry_in = new_entry;
               valid_in = 1'b1;
            end else begin
               entry_in = left_entry;
               valid_in = left_valid;
            end
         end
      end else if (cmd.pop) begin
         entry_in = right_entry;
         valid_in = right_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;
   assign valid = valid_ff;

endmodule

/* rtl/core/sjn_queue.sv */
module sjn_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  sjn_pkg::queue_cmd_type   cmd,
   input  sjn_pkg::entry_type       new_entry,
   output sjn_pkg::queue_status_type status
);
   import sjn_pkg::*;

   entry_type              entries [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0] valid_vec;
   logic [QUEUE_DEPTH-1:0] keep_vec;
   logic [CNT_W-1:0]       count_ff, count_in;

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      entry_type left_entry, right_entry;
      logic      left_valid, left_keep, right_valid;

      if (i == 0) begin : g_first
         assign left_entry = new_entry;
         assign left_valid = 1'b0;
         assign left_keep  = 1'b1;
      end else begin : g_mid
         assign left_entry = entries[i-1];
         assign left_valid = valid_vec[i-1];
         assign left_keep  = keep_vec[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_last
         assign right_entry = new_entry;
         assign right_valid = 1'b0;
      end else begin : g_inner
         assign right_entry = entries[i+1];
         assign right_valid = valid_vec[i+1];
      end

      sjn_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .new_entry   (new_entry),
         .left_entry  (left_entry),
         .left_valid  (left_valid),
         .left_keep   (left_keep),
         .right_entry (right_entry),
         .right_valid (right_valid),
         .entry       (entries[i]),
         .valid       (valid_vec[i]),
         .keep        (keep_vec[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.push) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.pop) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign status.head       = entries[0];
   assign status.head_valid = valid_vec[0];
   assign status.full       = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign status.count      = count_ff;

`ifndef ASSERT_OFF
   a_count_matches: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_vec) == int'(count_ff))
      else $error("queue count out of step with valid cells");

   a_valid_prefix: assert property (@(posedge clock) disable iff (reset)
      (valid_vec & (valid_vec + {{(QUEUE_DEPTH-1){1'b0}}, 1'b1})) == '0)
      else $error("valid cells do not form a prefix");

   a_cmd_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(cmd.push && cmd.pop) && !(cmd.push && status.full) &&
      !(cmd.pop && !status.head_valid))
      else $error("illegal queue command");
`endif

endmodule

/* rtl/core/shortest_job_next_scheduler_unit.sv */
// Non-preemptive shortest-job-next scheduler. Pulse start with a request while
// busy is low; busy then stays high for one cycle while a row of cells keeps
// the ready queue sorted by requested time (ties in arrival order), and a start
// while busy is high is ignored. The response for an item appears on rsp_data
// with rsp_strobe high for exactly one cycle, in the cycle after busy; it must
// be captured then, there is no way to hold it. An arrival on a full queue is
// dropped with accepted 0. There is no clearing pass: the block is ready right
// after reset.
module shortest_job_next_scheduler_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  sjn_pkg::req_type req_data,
   output logic             rsp_strobe,
   output sjn_pkg::rsp_type rsp_data
);
   import sjn_pkg::*;

   logic             pend_ff;
   req_type          req_ff;
   rsp_type          rsp_ff, rsp_in;
   logic             strobe_ff;
   logic [31:0]      counter_ff, counter_in;
   logic [31:0]      finish_ff, finish_in;
   logic             proc_busy_ff, proc_busy_in;
   logic [7:0]       current_ff, current_in;

   queue_cmd_type    qcmd;
   queue_status_type qstat;
   entry_type        new_entry;
   logic             still_busy;
   logic [CNT_W-1:0] count_after;
   logic [31:0]      count_wide;

   assign new_entry.task_id        = req_ff.task_id;
   assign new_entry.run_length     = req_ff.run_length;
   assign new_entry.requested_time = req_ff.requested_time;

   sjn_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .cmd       (qcmd),
      .new_entry (new_entry),
      .status    (qstat)
   );

   always_comb begin
      qcmd.push    = 1'b0;
      qcmd.pop     = 1'b0;
      counter_in   = counter_ff;
      finish_in    = finish_ff;
      proc_busy_in = proc_busy_ff;
      current_in   = current_ff;
      still_busy   = proc_busy_ff && (counter_ff != finish_ff);
      count_after  = qstat.count;
      if (pend_ff) begin
         if (req_ff.operation == OP_ARRIVE) begin
            qcmd.push = !qstat.full;
            if (!qstat.full) begin
               count_after = qstat.count + CNT_W'(1);
            end
         end else begin
            proc_busy_in = still_busy;
            if (!still_busy && qstat.head_valid) begin
               qcmd.pop     = 1'b1;
               count_after  = qstat.count - CNT_W'(1);
               current_in   = qstat.head.task_id;
               finish_in    = counter_ff + 32'(qstat.head.run_length);
               proc_busy_in = 1'b1;
            end
            counter_in = counter_ff + 32'd1;
         end
      end
      count_wide = 32'(count_after);
   end

   always_comb begin
      rsp_in.cycle_now     = counter_ff;
      rsp_in.running_task  = current_in;
      rsp_in.busy_res      = proc_busy_in;
      rsp_in.dispatched    = qcmd.pop;
      rsp_in.waiting_count = count_wide[4:0];
      rsp_in.accepted      = qcmd.push;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= 1'b0;
         strobe_ff    <= 1'b0;
         counter_ff   <= 32'd1;
         finish_ff    <= '0;
         proc_busy_ff <= 1'b0;
         current_ff   <= '0;
      end else begin
         pend_ff      <= start && !pend_ff;
         strobe_ff    <= pend_ff;
         counter_ff   <= counter_in;
         finish_ff    <= finish_in;
         proc_busy_ff <= proc_busy_in;
         current_ff   <= current_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start && !pend_ff) begin
         req_ff <= req_data;
      end
      if (pend_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign busy       = pend_ff;
   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

`ifndef ASSERT_OFF
   a_beat_follows: assert property (@(posedge clock) disable iff (reset)
      busy |=> rsp_strobe)
      else $error("accepted beat produced no response");

   a_dispatch_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.dispatched |-> rsp_data.busy_res && !rsp_data.accepted)
      else $error("dispatch without busy processor");

   a_tick_advances: assert property (@(posedge clock) disable iff (reset)
      pend_ff && (req_ff.operation == OP_TICK) |=> counter_ff == $past(counter_ff) + 32'd1)
      else $error("cycle counter did not advance on tick");
`endif

endmodule
